/* hdl/ows_pkg.sv */
// ----------------------------------------------------------------------------
// ows_pkg: shared types and constants of the 1-Wire ROM search engine.
// Holds the function and status codes and the item and result records.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ows_pkg;

  // Number of ROM bits walked in one search pass.
  localparam int unsigned ROM_BITS = 64;
  // Width of the stored ROM code and of the bit counters.
  localparam int unsigned RomW = 64;
  localparam int unsigned PosW = 7;
  localparam int unsigned IdxW = 6;
  localparam logic [PosW-1:0] RomBitsPos = PosW'(ROM_BITS);

  // Function codes of an input item.
  typedef enum logic [1:0] {
    FUNC_NEW   = 2'd0,
    FUNC_START = 2'd1,
    FUNC_PAIR  = 2'd2
  } func_e;

  // Status codes of a result item.
  typedef enum logic [1:0] {
    STAT_BUSY = 2'd0,
    STAT_MORE = 2'd1,
    STAT_LAST = 2'd2,
    STAT_NONE = 2'd3
  } status_e;

  // One input item as held in the input register.
  typedef struct packed {
    logic [1:0] func;
    logic       presence;
    logic       id_bit;
    logic       cmp_bit;
  } item_t;

  // One result item as held in the result register.
  typedef struct packed {
    logic            dir_bit;
    logic            write_valid;
    logic            pass_done;
    status_e         status;
    logic [RomW-1:0] rom_code;
    logic [PosW-1:0] bit_position;
  } result_t;

endpackage

`default_nettype wire

/* hdl/ows_if.sv */
// ----------------------------------------------------------------------------
// ows_if: ready/valid channels of the ROM search engine.
// One interface carries input items, the other carries result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ows_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic       presence;
  logic       id_bit;
  logic       cmp_bit;

  modport source (output valid, func, presence, id_bit, cmp_bit, input ready);
  modport sink   (input valid, func, presence, id_bit, cmp_bit, output ready);
endinterface

interface ows_result_if;
  logic       valid;
  logic       ready;
  logic       dir_bit;
  logic       write_valid;
  logic       pass_done;
  logic [1:0] status;
  logic [63:0] rom_code;
  logic [6:0] bit_position;

  modport source (output valid, dir_bit, write_valid, pass_done, status, rom_code,
                  bit_position, input ready);
  modport sink   (input valid, dir_bit, write_valid, pass_done, status, rom_code,
                  bit_position, output ready);
endinterface

`default_nettype wire

/* hdl/one_wire_rom_search_top.sv */
// ----------------------------------------------------------------------------
// one_wire_rom_search_top: bit-level 1-Wire ROM search engine.
// Items and results are registered. Throughput: one item per cycle while the
// output is not stalled, set by the single decision stage in ows_core.
// Reset: asynchronous and active low; clears the ROM code, the positions and
// the pass flag, and empties both registers. No clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module one_wire_rom_search_top (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  ows_item_if.sink    item_i,
  ows_result_if.source result_o
);
  import ows_pkg::*;

  logic    in_vld_q, in_vld_d;
  item_t   in_item_q;
  logic    out_vld_q, out_vld_d;
  result_t out_res_q;
  result_t res;
  logic    take;
  logic    step;

  // Handshake: the held item moves on whenever the result register frees up.
  assign take  = item_i.valid && item_i.ready;
  assign step  = in_vld_q && (!out_vld_q || result_o.ready);
  assign item_i.ready = !in_vld_q || step;
  assign in_vld_d  = take || (in_vld_q && !step);
  assign out_vld_d = step || (out_vld_q && !result_o.ready);

  ows_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_q),
    .res_o  (res)
  );

  // Valid flags of the input and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (take) begin
      in_item_q.func     <= item_i.func;
      in_item_q.presence <= item_i.presence;
      in_item_q.id_bit   <= item_i.id_bit;
      in_item_q.cmp_bit  <= item_i.cmp_bit;
    end
    if (step) begin
      out_res_q <= res;
    end
  end

  // Result channel.
  assign result_o.valid        = out_vld_q;
  assign result_o.dir_bit      = out_res_q.dir_bit;
  assign result_o.write_valid  = out_res_q.write_valid;
  assign result_o.pass_done    = out_res_q.pass_done;
  assign result_o.status       = out_res_q.status;
  assign result_o.rom_code     = out_res_q.rom_code;
  assign result_o.bit_position = out_res_q.bit_position;

`ifndef ASSERT_OFF
  // With both registers full and the output stalled, no item is taken.
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !result_o.ready) |-> !item_i.ready)
    else $error("item taken while both registers are full");

  // A stepped item always shows up as a result in the next cycle.
  a_step_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_vld_q)
    else $error("stepped item did not reach the result register");

  // An accepted item is held in the input register in the next cycle.
  a_take_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> in_vld_q)
    else $error("accepted item lost");
`endif

endmodule

`default_nettype wire

/* hdl/ows_core.sv */
// ----------------------------------------------------------------------------
// ows_core: search state and per-bit direction decision.
// Computes the result of one item from the current state and commits the
// new state when the item is stepped into the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ows_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire ows_pkg::item_t   item_i,
  output ows_pkg::result_t      res_o
);
  import ows_pkg::*;

  logic [RomW-1:0] rom_q, rom_d;
  logic [PosW-1:0] last_zero_q, last_zero_d;
  logic [PosW-1:0] pass_mark_q, pass_mark_d;
  logic [PosW-1:0] bit_index_q, bit_index_d;
  logic            active_q, active_d;

  logic [PosW-1:0] pos;
  logic [IdxW-1:0] sh;
  logic            choice;

  // 1-based position of the bit being decided and its place in the ROM code.
  assign pos = bit_index_q + PosW'(1);
  assign sh  = bit_index_q[IdxW-1:0];

  // Next state and result of the held item.
  always_comb begin
    rom_d       = rom_q;
    last_zero_d = last_zero_q;
    pass_mark_d = pass_mark_q;
    bit_index_d = bit_index_q;
    active_d    = active_q;
    choice      = 1'b0;
    res_o.dir_bit     = 1'b0;
    res_o.write_valid = 1'b0;
    res_o.pass_done   = 1'b0;
    res_o.status      = STAT_BUSY;
    unique case (item_i.func)
      FUNC_NEW: begin
        rom_d       = '0;
        last_zero_d = '0;
        pass_mark_d = '0;
        bit_index_d = '0;
        active_d    = 1'b0;
      end
      FUNC_START: begin
        if (item_i.presence) begin
          pass_mark_d = last_zero_q;
          bit_index_d = '0;
          active_d    = 1'b1;
        end else begin
          active_d        = 1'b0;
          res_o.pass_done = 1'b1;
          res_o.status    = STAT_NONE;
        end
      end
      FUNC_PAIR: begin
        if (active_q) begin
          if (item_i.id_bit && item_i.cmp_bit) begin
            // No device answered this slot pair.
            active_d        = 1'b0;
            res_o.pass_done = 1'b1;
            res_o.status    = STAT_NONE;
          end else begin
            if (!item_i.id_bit && !item_i.cmp_bit) begin
              // Discrepancy: follow the mark of the previous pass.
              if (pos > pass_mark_q) begin
                choice = 1'b0;
              end else if (pos == pass_mark_q) begin
                choice = 1'b1;
              end else begin
                choice = rom_q[sh];
              end
              if (!choice) begin
                last_zero_d = pos;
              end
            end else begin
              choice = ~item_i.cmp_bit;
            end
            rom_d[sh]         = choice;
            res_o.dir_bit     = choice;
            res_o.write_valid = 1'b1;
            bit_index_d       = pos;
            if (pos >= RomBitsPos) begin
              active_d        = 1'b0;
              res_o.pass_done = 1'b1;
              res_o.status    = (last_zero_d == pass_mark_q) ? STAT_LAST : STAT_MORE;
            end
          end
        end
      end
      default: begin
      end
    endcase
    res_o.rom_code     = rom_d;
    res_o.bit_position = bit_index_d;
  end

  // Search state, committed once per stepped item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_q       <= '0;
      last_zero_q <= '0;
      pass_mark_q <= '0;
      bit_index_q <= '0;
      active_q    <= 1'b0;
    end else if (step_i) begin
      rom_q       <= rom_d;
      last_zero_q <= last_zero_d;
      pass_mark_q <= pass_mark_d;
      bit_index_q <= bit_index_d;
      active_q    <= active_d;
    end
  end

`ifndef ASSERT_OFF
  // A direction bit is only produced inside an active pass.
  a_write_needs_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.write_valid |-> active_q)
    else $error("direction bit produced outside a pass");

  // The bit counter never runs past the ROM length.
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_index_q <= RomBitsPos)
    else $error("bit counter beyond ROM length");

  // A pass that finished leaves the engine idle.
  a_done_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.pass_done) |=> !active_q)
    else $error("engine still active after pass end");
`endif

endmodule

`default_nettype wire

/* dv/one_wire_rom_search_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_rom_search_top_test: self-checking bench for the ROM search engine.
// An opening table walks the idle, abort, restart and conflict rules one item
// at a time. After that, simulated device populations answer each slot pair by
// wired-AND, so full searches run pass after pass to found-last. Rare foreign
// items break in. Results are checked against known table rows or an engine copy.
// ----------------------------------------------------------------------------

module one_wire_rom_search_top_test;
  import ows_pkg::*;

  localparam int          RandomItems = 1350;
  localparam int          CycleLimit  = 400000;
  localparam int          MaxDevs     = 5;
  localparam int          PlanLen     = 22;
  localparam logic [1:0]  FuncUnused  = 2'd3;

  // One row of the opening table: the item, and where known, its result.
  typedef struct packed {
    logic [1:0]      func;
    logic            presence;
    logic            id_bit;
    logic            cmp_bit;
    logic            known;
    logic            done;
    status_e         status;
    logic [RomW-1:0] rom;
    logic [PosW-1:0] pos;
  } plan_row_t;

  localparam plan_row_t OpeningPlan [PlanLen] = '{
    // Pair 1/1 and the unused code straight after reset are ignored.
    '{FUNC_PAIR,  1'b0, 1'b1, 1'b1, 1'b1, 1'b0, STAT_BUSY, 64'h0, 7'd0},
    '{FuncUnused, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, STAT_BUSY, 64'h0, 7'd0},
    // Missing presence ends the pass at once.
    '{FUNC_START, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, STAT_NONE, 64'h0, 7'd0},
    // First pass: both plain directions, two conflicts beyond the mark, then 1/1.
    '{FUNC_START, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, STAT_BUSY, 64'h0, 7'd0},
    '{FUNC_PAIR,  1'b0, 1'b0, 1'b1, 1'b0, 1'b0, STAT_BUSY, 64'h0, 7'd0},
    '{FUNC_PAIR,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0, STAT_BUSY, 64'h0, 7'd0},
    '{FUNC_PAIR,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, STAT_BUSY, 64'h0, 7'd0},
    '{FUNC_PAIR,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, STAT_BUSY, 64'h0, 7'd0},
    '{FUNC_PAIR,  1'b0, 1'b1, 1'b1, 1'b0, 1'b0, STAT_BUSY, 64'h0, 7'd0},
    '{FUNC_PAIR,  1'b0, 1'b0, 1'b1, 1'b0, 1'b0, STAT_BUSY, 64'h0, 7'd0},
    // Second pass: conflicts before, at and beyond the kept mark.
    '{FUNC_START, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, STAT_BUSY, 64'h0, 7'd0},
    '{FUNC_PAIR,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0, STAT_BUSY, 64'h0, 7'd0},
    '{FUNC_PAIR,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, STAT_BUSY, 64'h0, 7'd0},
    '{FUNC_PAIR,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, STAT_BUSY, 64'h0, 7'd0},
    '{FUNC_PAIR,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, STAT_BUSY, 64'h0, 7'd0},
    '{FUNC_PAIR,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, STAT_BUSY, 64'h0, 7'd0},
    // Restart while a pass is running, then lose presence mid-pass.
    '{FUNC_START, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, STAT_BUSY, 64'h0, 7'd0},
    '{FUNC_PAIR,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, STAT_BUSY, 64'h0, 7'd0},
    '{FUNC_START, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, STAT_BUSY, 64'h0, 7'd0},
    // New search clears everything; idle items after it are ignored.
    '{FUNC_NEW,   1'b1, 1'b1, 1'b1, 1'b1, 1'b0, STAT_BUSY, 64'h0, 7'd0},
    '{FUNC_PAIR,  1'b0, 1'b0, 1'b0, 1'b1, 1'b0, STAT_BUSY, 64'h0, 7'd0},
    '{FuncUnused, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, STAT_BUSY, 64'h0, 7'd0}
  };

  // Clock and reset.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #6 clk_i = ~clk_i;

  // Bench-side drivers of the two channels, known from time zero.
  logic       src_valid    = 1'b0;
  logic [1:0] src_func     = FUNC_NEW;
  logic       src_presence = 1'b0;
  logic       src_id_bit   = 1'b0;
  logic       src_cmp_bit  = 1'b0;
  logic       sink_ready   = 1'b0;

  ows_item_if   item_bus ();
  ows_result_if result_bus ();

  assign item_bus.valid    = src_valid;
  assign item_bus.func     = src_func;
  assign item_bus.presence = src_presence;
  assign item_bus.id_bit   = src_id_bit;
  assign item_bus.cmp_bit  = src_cmp_bit;
  assign result_bus.ready  = sink_ready;

  one_wire_rom_search_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (result_bus)
  );

  // Bench copy of the engine state.
  logic [RomW-1:0] code_bits   = '0;
  logic [PosW-1:0] zero_pos    = '0;
  logic [PosW-1:0] branch_mark = '0;
  logic [PosW-1:0] bits_done   = '0;
  logic            in_pass     = 1'b0;

  result_t pending_results [$];
  int      items_sent     = 0;
  int      mismatch_count = 0;
  int      cycle_count    = 0;
  int      stall_left     = 0;
  wire     quiet_tail     = (items_sent > PlanLen + RandomItems - 150);

  // Simulated devices on the bus.
  logic [RomW-1:0]    dev_rom [MaxDevs];
  logic [MaxDevs-1:0] dev_live;
  int                 dev_count;

  // Works out the result of one accepted item and advances the engine copy.
  function automatic result_t search_decide(input item_t it);
    result_t         r;
    logic [PosW-1:0] pos;
    logic [IdxW-1:0] sh;
    logic            choice;
    r      = '0;
    pos    = bits_done + 1'b1;
    sh     = IdxW'(bits_done);
    choice = 1'b0;
    case (it.func)
      FUNC_NEW: begin
        code_bits   = '0;
        zero_pos    = '0;
        branch_mark = '0;
        bits_done   = '0;
        in_pass     = 1'b0;
      end
      FUNC_START: begin
        if (it.presence) begin
          branch_mark = zero_pos;
          bits_done   = '0;
          in_pass     = 1'b1;
        end else begin
          in_pass     = 1'b0;
          r.pass_done = 1'b1;
          r.status    = STAT_NONE;
        end
      end
      FUNC_PAIR: begin
        if (in_pass && it.id_bit && it.cmp_bit) begin
          // Nobody answered the slot pair.
          in_pass     = 1'b0;
          r.pass_done = 1'b1;
          r.status    = STAT_NONE;
        end else if (in_pass) begin
          if (!it.id_bit && !it.cmp_bit) begin
            // Conflict: take the branch dictated by the discrepancy mark.
            if (pos > branch_mark) begin
              choice = 1'b0;
            end else if (pos == branch_mark) begin
              choice = 1'b1;
            end else begin
              choice = code_bits[sh];
            end
            if (!choice) zero_pos = pos;
          end else begin
            choice = ~it.cmp_bit;
          end
          code_bits[sh] = choice;
          r.dir_bit     = choice;
          r.write_valid = 1'b1;
          bits_done     = pos;
          if (pos >= RomBitsPos) begin
            in_pass     = 1'b0;
            r.pass_done = 1'b1;
            r.status    = (zero_pos == branch_mark) ? STAT_LAST : STAT_MORE;
          end
        end
      end
      default: ;
    endcase
    r.rom_code     = code_bits;
    r.bit_position = bits_done;
    return r;
  endfunction

  // Offers one item, waits for its transaction and queues what it must produce.
  task automatic send_item(input logic [1:0] func, input logic presence,
                           input logic id_bit, input logic cmp_bit,
                           input logic known, input result_t known_result,
                           output result_t predicted);
    item_t it;
    if (!quiet_tail && cycle_count[7] && $urandom_range(0, 3) == 0) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    src_valid    <= 1'b1;
    src_func     <= func;
    src_presence <= presence;
    src_id_bit   <= id_bit;
    src_cmp_bit  <= cmp_bit;
    @(posedge clk_i);
    while (item_bus.ready !== 1'b1) @(posedge clk_i);
    it.func     = func;
    it.presence = presence;
    it.id_bit   = id_bit;
    it.cmp_bit  = cmp_bit;
    predicted   = search_decide(it);
    pending_results.push_back(known ? known_result : predicted);
    items_sent++;
  endtask

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Cycle counter and run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL one_wire_rom_search_top");
      $finish;
    end
  end

  // Result back-pressure in bursts, only in alternate stretches of the run.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      sink_ready <= 1'b0;
    end else if (!quiet_tail && cycle_count[8] && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 5);
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Compares each result transaction with the oldest queued expectation.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_bus.valid === 1'b1 && sink_ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result rom %h pos %0d",
                                result_bus.rom_code, result_bus.bit_position));
      end else begin
        want = pending_results.pop_front();
        if (result_bus.dir_bit !== want.dir_bit ||
            result_bus.write_valid !== want.write_valid ||
            result_bus.pass_done !== want.pass_done ||
            result_bus.status !== want.status ||
            result_bus.rom_code !== want.rom_code ||
            result_bus.bit_position !== want.bit_position) begin
          note_mismatch($sformatf(
            {"exp wb %b wv %b done %b st %0d rom %h pos %0d, ",
             "got wb %b wv %b done %b st %0d rom %h pos %0d"},
            want.dir_bit, want.write_valid, want.pass_done, want.status,
            want.rom_code, want.bit_position,
            result_bus.dir_bit, result_bus.write_valid, result_bus.pass_done,
            result_bus.status, result_bus.rom_code, result_bus.bit_position));
        end
      end
    end
  end

  // Stimulus: opening table, then device searches with occasional foreign items.
  initial begin
    result_t         got;
    result_t         want;
    logic [RomW-1:0] base;
    logic            id_b;
    logic            cmp_b;
    logic            pres;
    logic            search_over;
    int              flip;
    int              pass_no;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (OpeningPlan[i]) begin
      want              = '0;
      want.pass_done    = OpeningPlan[i].done;
      want.status       = OpeningPlan[i].status;
      want.rom_code     = OpeningPlan[i].rom;
      want.bit_position = OpeningPlan[i].pos;
      send_item(OpeningPlan[i].func, OpeningPlan[i].presence, OpeningPlan[i].id_bit,
                OpeningPlan[i].cmp_bit, OpeningPlan[i].known, want, got);
    end

    while (items_sent < PlanLen + RandomItems) begin
      // A population of related codes, so conflicts fall deep into the code.
      case ($urandom_range(0, 7))
        0:       base = '0;
        1:       base = '1;
        default: base = {$urandom, $urandom};
      endcase
      dev_count = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, MaxDevs);
      for (int d = 0; d < MaxDevs; d++) begin
        dev_rom[d] = base;
        if ($urandom_range(0, 4) == 0) begin
          dev_rom[d] = {$urandom, $urandom};
        end else begin
          repeat ($urandom_range(0, 4)) begin
            flip             = $urandom_range(0, RomW - 1);
            dev_rom[d][flip] = ~dev_rom[d][flip];
          end
        end
      end

      // Now and then the new search is left out, so stale state carries over.
      if ($urandom_range(0, 7) != 0) begin
        send_item(FUNC_NEW, 1'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0, got);
      end

      search_over = 1'b0;
      pass_no     = 0;
      while (!search_over && pass_no < 12 && items_sent < PlanLen + RandomItems) begin
        pass_no++;
        pres = (dev_count != 0);
        if ($urandom_range(0, 39) == 0) pres = ~pres;
        send_item(FUNC_START, pres, 1'($urandom), 1'($urandom), 1'b0, '0, got);
        dev_live = '1;
        for (int k = 0; k < ROM_BITS && in_pass && !search_over &&
             items_sent < PlanLen + RandomItems; k++) begin
          if ($urandom_range(0, 199) == 0) begin
            // A foreign item breaks into the pass; the search is given up.
            send_item(2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom), 1'($urandom),
                      1'b0, '0, got);
            search_over = 1'b1;
          end else begin
            // Wired-AND read of the bit and its complement from live devices.
            id_b  = 1'b1;
            cmp_b = 1'b1;
            for (int d = 0; d < dev_count; d++) begin
              if (dev_live[d]) begin
                id_b  = id_b & dev_rom[d][k];
                cmp_b = cmp_b & ~dev_rom[d][k];
              end
            end
            send_item(FUNC_PAIR, 1'($urandom), id_b, cmp_b, 1'b0, '0, got);
            for (int d = 0; d < dev_count; d++) begin
              if (dev_rom[d][k] != got.dir_bit) dev_live[d] = 1'b0;
            end
          end
        end
        if (!search_over) search_over = (got.status != STAT_MORE);
      end
    end
    src_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS one_wire_rom_search_top");
    end else begin
      $display("FAIL one_wire_rom_search_top");
    end
    $finish;
  end

endmodule

/* one_wire_rom_search_top.f */
hdl/ows_pkg.sv
hdl/ows_if.sv
hdl/ows_core.sv
hdl/one_wire_rom_search_top.sv
dv/one_wire_rom_search_top_test.sv
